@@ rtl/egbr_pkg.sv @@
// Shared types and operation codes for the Exp-Golomb bitstream reader.
`default_nettype none
package egbr_pkg;

   typedef logic [3:0] op_type;

   localparam op_type OP_START  = 4'd0;
   localparam op_type OP_APPEND = 4'd1;
   localparam op_type OP_READ   = 4'd2;
   localparam op_type OP_UE     = 4'd3;
   localparam op_type OP_SE     = 4'd4;
   localparam op_type OP_SKIP   = 4'd5;
   localparam op_type OP_ALIGN  = 4'd6;
   localparam op_type OP_PEEK   = 4'd7;
   localparam op_type OP_MORE   = 4'd8;
   localparam op_type OP_NOP    = 4'd15;

   localparam int MAX_READ_BITS = 64;
   localparam int MAX_ZEROS     = 32;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [15:0] count;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/egbr_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface egbr_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [7:0]  data_byte;
   logic [15:0] count;
   modport source (output valid, output operation, output data_byte, output count,
                   input ready);
   modport sink (input valid, input operation, input data_byte, input count,
                 output ready);
endinterface

interface egbr_rsp_if;
   logic               valid;
   logic               ready;
   logic [63:0]        value;
   logic signed [31:0] signed_value;
   logic               flag;
   logic               ok;
   logic [15:0]        bits_left;
   modport source (output valid, output value, output signed_value, output flag,
                   output ok, output bits_left, input ready);
   modport sink (input valid, input value, input signed_value, input flag,
                 input ok, input bits_left, output ready);
endinterface
`default_nettype wire

@@ rtl/egbr_front.sv @@
// Front stage: takes request transfers and classifies the operation code.
`default_nettype none
module egbr_front import egbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   egbr_req_if.sink req_chan,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_ready
);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_chan.ready = !valid_ff || cmd_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (cmd_ready) valid_in = 1'b0;
      if (take) valid_in = 1'b1;
      cmd_in.op        = (req_chan.operation > OP_MORE) ? OP_NOP : req_chan.operation;
      cmd_in.data_byte = req_chan.data_byte;
      cmd_in.count     = req_chan.count;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (take) cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd = cmd_ff;
endmodule
`default_nettype wire

@@ rtl/egbr_queue.sv @@
// Two-entry command queue between front and back.
`default_nettype none
module egbr_queue import egbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    pop_valid
);
   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid = fill_ff != 2'd0;
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end
endmodule
`default_nettype wire

@@ rtl/egbr_back.sv @@
// Back end: byte store, bit position state, bit-serial decoder and response register.
`default_nettype none
module egbr_back import egbr_pkg::*; #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   egbr_rsp_if.source rsp_chan
);
   localparam int LW = $clog2(BUFFER_BYTES + 1);
   localparam int PW = LW + 3;
   localparam int AW = $clog2(BUFFER_BYTES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_BIT   = 3'd2;
   localparam logic [2:0] ST_SFTCH = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [7:0] mem [BUFFER_BYTES];

   logic [2:0]    state_ff, state_in;
   op_type        op_ff, op_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ok_ff, ok_in;
   logic [63:0]   acc_ff, acc_in;
   logic [6:0]    need_ff, need_in;
   logic [5:0]    zeros_ff, zeros_in;
   logic          suffix_ff, suffix_in;
   logic          flag_ff, flag_in;
   logic [63:0]   val_ff, val_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic [7:0]    rd_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_value_ff;
   logic signed [31:0] rsp_sval_ff;
   logic               rsp_flag_ff, rsp_ok_ff;
   logic [15:0]        rsp_left_ff;
   logic               rsp_load;

   logic [PW-1:0] total, rem, rem1, pos_inc, align_step;
   logic          bit_now, boundary, wr_en, fail;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] scan_next;
   logic [31:0]   prefix_val, code, mag;

   assign total = {len_ff, 3'b000};
   assign rem = total - pos_ff;
   assign rem1 = rem - 1'b1;
   assign pos_inc = pos_ff + 1'b1;
   assign boundary = pos_ff[2:0] == 3'd7;
   assign bit_now = rd_ff[3'd7 - pos_ff[2:0]];
   assign align_step = PW'(4'd8 - {1'b0, pos_ff[2:0]});
   assign prefix_val = (32'd1 << zeros_ff) - 32'd1;
   assign scan_next = scan_ff + 1'b1;
   assign rd_addr = (state_ff == ST_SFTCH) ? scan_ff[AW-1:0] : pos_ff[3 +: AW];
   assign code = val_ff[31:0];
   assign mag = 32'((33'(code) + 33'd1) >> 1);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      ok_in = ok_ff;
      acc_in = acc_ff;
      need_in = need_ff;
      zeros_in = zeros_ff;
      suffix_in = suffix_ff;
      flag_in = flag_ff;
      val_in = val_ff;
      scan_in = scan_ff;
      wr_en = 1'b0;
      fail = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in = cmd.op;
               val_in = '0;
               flag_in = 1'b0;
               acc_in = '0;
               zeros_in = '0;
               suffix_in = 1'b0;
               need_in = cmd.count[6:0];
               state_in = ST_DONE;
               unique case (cmd.op)
                  OP_START: begin
                     len_in = '0;
                     pos_in = '0;
                     ok_in = 1'b1;
                  end
                  OP_APPEND: begin
                     if (32'(len_ff) == BUFFER_BYTES) fail = 1'b1;
                     else begin
                        wr_en = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (32'(cmd.count) > MAX_READ_BITS || 32'(rem) < 32'(cmd.count))
                        fail = 1'b1;
                     else if (cmd.count != 16'd0) state_in = ST_FETCH;
                  end
                  OP_UE, OP_SE: begin
                     if (rem == '0) fail = 1'b1;
                     else state_in = ST_FETCH;
                  end
                  OP_SKIP: begin
                     if (32'(rem) < 32'(cmd.count)) fail = 1'b1;
                     else pos_in = pos_ff + cmd.count[PW-1:0];
                  end
                  OP_ALIGN: begin
                     if (pos_ff[2:0] != 3'd0) begin
                        if (rem < align_step) fail = 1'b1;
                        else pos_in = pos_ff + align_step;
                     end
                  end
                  OP_PEEK, OP_MORE: begin
                     if (rem != '0) state_in = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: state_in = ST_BIT;
         ST_SFTCH: state_in = ST_SCAN;
         ST_BIT: begin
            priority if (op_ff == OP_READ || suffix_ff) begin
               acc_in = {acc_ff[62:0], bit_now};
               pos_in = pos_inc;
               need_in = need_ff - 1'b1;
               if (need_ff == 7'd1) begin
                  state_in = ST_DONE;
                  if (op_ff == OP_READ) val_in = acc_in;
                  else val_in = 64'(prefix_val + acc_in[31:0]);
               end else state_in = boundary ? ST_FETCH : ST_BIT;
            end else if (op_ff == OP_UE || op_ff == OP_SE) begin
               pos_in = pos_inc;
               if (!bit_now) begin
                  zeros_in = zeros_ff + 1'b1;
                  if (32'(zeros_ff) == MAX_ZEROS - 1 || rem1 == '0) begin
                     fail = 1'b1;
                     state_in = ST_DONE;
                  end else state_in = boundary ? ST_FETCH : ST_BIT;
               end else if (zeros_ff == '0) begin
                  state_in = ST_DONE;
               end else if (32'(rem1) < 32'(zeros_ff)) begin
                  fail = 1'b1;
                  val_in = 64'(prefix_val);
                  state_in = ST_DONE;
               end else begin
                  suffix_in = 1'b1;
                  need_in = {1'b0, zeros_ff};
                  acc_in = '0;
                  state_in = boundary ? ST_FETCH : ST_BIT;
               end
            end else if (op_ff == OP_PEEK) begin
               flag_in = bit_now;
               state_in = ST_DONE;
            end else begin
               if (!bit_now || (rd_ff & (8'h7F >> pos_ff[2:0])) != 8'd0) begin
                  flag_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  scan_in = pos_ff[PW-1:3] + 1'b1;
                  state_in = (scan_in == len_ff) ? ST_DONE : ST_SFTCH;
               end
            end
         end
         ST_SCAN: begin
            if (rd_ff != 8'd0) begin
               flag_in = 1'b1;
               state_in = ST_DONE;
            end else if (scan_next == len_ff) state_in = ST_DONE;
            else begin
               scan_in = scan_next;
               state_in = ST_SFTCH;
            end
         end
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (fail) begin
         ok_in = 1'b0;
         pos_in = total;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         len_ff <= '0;
         ok_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         ok_ff <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      acc_ff <= acc_in;
      need_ff <= need_in;
      zeros_ff <= zeros_in;
      suffix_ff <= suffix_in;
      flag_ff <= flag_in;
      val_ff <= val_in;
      scan_ff <= scan_in;
      if (rsp_load) begin
         rsp_value_ff <= (op_ff == OP_READ || op_ff == OP_UE) ? val_ff : 64'd0;
         rsp_sval_ff <= (op_ff == OP_SE && ok_ff) ? (code[0] ? mag : -mag) : 32'sd0;
         rsp_flag_ff <= flag_ff;
         rsp_ok_ff <= ok_ff;
         rsp_left_ff <= 16'(rem);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[len_ff[AW-1:0]] <= cmd.data_byte;
      rd_ff <= mem[rd_addr];
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;
   assign rsp_chan.signed_value = rsp_sval_ff;
   assign rsp_chan.flag = rsp_flag_ff;
   assign rsp_chan.ok = rsp_ok_ff;
   assign rsp_chan.bits_left = rsp_left_ff;
endmodule
`default_nettype wire

@@ rtl/exp_golomb_bitstream_reader_core.sv @@
// Top level of the Exp-Golomb bitstream reader.
// Path: front register, queue, back end. Control operations go straight to the
// response state; bit operations shift a bit per step with a fetch per byte touched;
// the more-data scan fetches and tests each byte. Fetches read the single-port store.
// The back end works on one operation; the front and queue take up to three more
// requests. Synchronous reset empties the buffer and sets ok.
`default_nettype none
module exp_golomb_bitstream_reader_core import egbr_pkg::*; #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   egbr_req_if.sink    req_chan,
   egbr_rsp_if.source  rsp_chan
);
   logic    f_valid, f_ready, q_valid, q_pop;
   cmd_type f_cmd, q_cmd;

   egbr_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
   );

   egbr_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_cmd(f_cmd), .push_ready(f_ready),
      .pop(q_pop), .pop_cmd(q_cmd), .pop_valid(q_valid)
   );

   egbr_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop), .rsp_chan(rsp_chan)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_se_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.signed_value != 0) |-> rsp_chan.ok)
      else $error("signed result with ok clear");
   a_flag_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.flag) |-> (rsp_chan.value == 0 &&
      rsp_chan.signed_value == 0)) else $error("flag with value");
endmodule
`default_nettype wire

@@ tb/exp_golomb_bitstream_reader_core_test.sv @@
// Self-checking testbench for the Exp-Golomb bitstream reader core.
`default_nettype none
module exp_golomb_bitstream_reader_core_test;
   import egbr_pkg::*;

   localparam int BUF_BYTES = 4096;
   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT = 400000;

   typedef struct packed {
      logic [63:0] value;
      logic [31:0] signed_value;
      logic        flag;
      logic        ok;
      logic [15:0] bits_left;
   } rsp_type;

   typedef struct {
      op_type      op;
      logic [7:0]  data_byte;
      logic [15:0] count;
      logic        known;
      rsp_type     rsp;
   } row_type;

   logic clock = 0;
   logic reset = 1;

   egbr_req_if req_chan ();
   egbr_rsp_if rsp_chan ();

   exp_golomb_bitstream_reader_core #(.BUFFER_BYTES(BUF_BYTES)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // reader state mirror
   logic [7:0]  mem [BUF_BYTES];
   int unsigned len_bytes;
   int unsigned pos_bits;
   logic        ok_bit;

   rsp_type expected_rsps [$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_stall = 0;
   bit stim_done = 0;

   function automatic int unsigned bits_remaining();
      return (pos_bits < len_bytes * 8) ? len_bytes * 8 - pos_bits : 0;
   endfunction

   function automatic logic bit_at(int unsigned p);
      return mem[(p >> 3) % BUF_BYTES][7 - (p & 7)];
   endfunction

   function automatic void fail_reader();
      ok_bit = 0;
      pos_bits = len_bytes * 8;
   endfunction

   function automatic logic [63:0] take_bits(int unsigned n);
      logic [63:0] v = 0;
      if (n > MAX_READ_BITS || bits_remaining() < n) begin
         fail_reader();
         return 0;
      end
      for (int i = 0; i < n; i++) begin
         v = {v[62:0], bit_at(pos_bits)};
         pos_bits++;
      end
      return v;
   endfunction

   function automatic logic [31:0] decode_ue_code();
      int unsigned zeros = 0;
      logic [31:0] base;
      while (bits_remaining() > 0 && bit_at(pos_bits) == 0) begin
         pos_bits++;
         zeros++;
         if (zeros >= MAX_ZEROS) begin
            fail_reader();
            return 0;
         end
      end
      if (bits_remaining() == 0) begin
         fail_reader();
         return 0;
      end
      pos_bits++;
      if (zeros == 0) return 0;
      base = (32'd1 << zeros) - 32'd1;
      return base + 32'(take_bits(zeros));
   endfunction

   function automatic void skip_ahead(int unsigned n);
      if (bits_remaining() < n) fail_reader();
      else pos_bits += n;
   endfunction

   function automatic logic more_rbsp();
      if (bits_remaining() == 0) return 0;
      if (bit_at(pos_bits) == 0) return 1;
      for (int unsigned p = pos_bits + 1; p < len_bytes * 8; p++)
         if (bit_at(p)) return 1;
      return 0;
   endfunction

   function automatic rsp_type reader_step(op_type op, logic [7:0] b, logic [15:0] cnt);
      rsp_type r;
      logic [31:0] code, mag;
      r = '0;
      case (op)
         OP_START: begin
            len_bytes = 0;
            pos_bits = 0;
            ok_bit = 1;
         end
         OP_APPEND: begin
            if (len_bytes >= BUF_BYTES) fail_reader();
            else begin
               mem[len_bytes] = b;
               len_bytes++;
            end
         end
         OP_READ: r.value = take_bits(cnt);
         OP_UE: r.value = {32'd0, decode_ue_code()};
         OP_SE: begin
            code = decode_ue_code();
            if (ok_bit) begin
               mag = (code + 32'd1) >> 1;
               r.signed_value = code[0] ? mag : 32'd0 - mag;
            end
         end
         OP_SKIP: skip_ahead(cnt);
         OP_ALIGN: if ((pos_bits & 7) != 0) skip_ahead(8 - (pos_bits & 7));
         OP_PEEK: r.flag = bits_remaining() > 0 ? bit_at(pos_bits) : 1'b0;
         OP_MORE: r.flag = more_rbsp();
         default: ;
      endcase
      r.ok = ok_bit;
      r.bits_left = 16'(bits_remaining());
      return r;
   endfunction

   function automatic rsp_type mk(logic [63:0] v, logic [31:0] s, logic f, logic o,
                                  logic [15:0] bl);
      rsp_type r;
      r.value = v; r.signed_value = s; r.flag = f; r.ok = o; r.bits_left = bl;
      return r;
   endfunction

   function automatic row_type row(op_type op, logic [7:0] b, logic [15:0] c);
      row_type t;
      t.op = op; t.data_byte = b; t.count = c; t.known = 0; t.rsp = '0;
      return t;
   endfunction

   function automatic row_type row_k(op_type op, logic [7:0] b, logic [15:0] c, rsp_type r);
      row_type t;
      t = row(op, b, c);
      t.known = 1; t.rsp = r;
      return t;
   endfunction

   function automatic int gap_len();
      int k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      if (k < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send(op_type op, logic [7:0] b, logic [15:0] c, logic known, rsp_type r);
      rsp_type p;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.operation <= op;
      req_chan.data_byte <= b;
      req_chan.count <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      p = reader_step(op, b, c);
      if (known && p !== r) begin
         errors++;
         if (errors <= 10)
            $display("table row disagrees with predictor: op %0d exp %h pred %h", op, r, p);
      end
      expected_rsps = {expected_rsps, p};
      @(negedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      int k = $urandom_range(0, 9);
      if (k < 3) return 8'h00;
      if (k < 4) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic load_buffer(int n);
      send(OP_START, 0, 0, 0, '0);
      for (int i = 0; i < n; i++) send(OP_APPEND, rand_byte(), 16'($urandom), 0, '0);
   endtask

   row_type table_rows [$];

   initial begin
      rsp_type z;
      op_type op;
      int k;
      z = '0;
      req_chan.valid = 0;
      req_chan.operation = OP_NOP;
      req_chan.data_byte = 0;
      req_chan.count = 0;
      len_bytes = 0; pos_bits = 0; ok_bit = 1;
      for (int i = 0; i < BUF_BYTES; i++) mem[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      table_rows = '{
         row_k(OP_PEEK, 0, 0, mk(0, 0, 0, 1, 0)),
         row_k(OP_MORE, 0, 0, mk(0, 0, 0, 1, 0)),
         row_k(OP_READ, 0, 0, mk(0, 0, 0, 1, 0)),
         row_k(OP_UE, 0, 0, mk(0, 0, 0, 0, 0)),
         row_k(OP_SE, 0, 0, mk(0, 0, 0, 0, 0)),
         row_k(OP_START, 8'hFF, 16'hFFFF, mk(0, 0, 0, 1, 0)),
         row_k(OP_APPEND, 8'hFF, 0, mk(0, 0, 0, 1, 8)),
         row_k(OP_APPEND, 8'h00, 0, mk(0, 0, 0, 1, 16)),
         row_k(OP_PEEK, 0, 0, mk(0, 0, 1, 1, 16)),
         row_k(OP_READ, 0, 4, mk(64'hF, 0, 0, 1, 12)),
         row(OP_UE, 0, 0),
         row(OP_SE, 0, 0),
         row(OP_SE, 0, 0),
         row(OP_ALIGN, 0, 0),
         row(OP_MORE, 0, 0),
         row_k(OP_READ, 0, 65, mk(0, 0, 0, 0, 0)),
         row_k(OP_START, 0, 0, mk(0, 0, 0, 1, 0)),
         row(OP_APPEND, 8'h00, 0),
         row(OP_APPEND, 8'h80, 0),
         row(OP_SKIP, 0, 3),
         row(OP_ALIGN, 0, 0),
         row_k(OP_SKIP, 0, 16'hFFFF, mk(0, 0, 0, 0, 0)),
         row_k(OP_NOP, 8'hFF, 16'hFFFF, mk(0, 0, 0, 0, 0)),
         row_k(op_type'(OP_MORE + 4'd1), 0, 0, mk(0, 0, 0, 0, 0))
      };
      foreach (table_rows[i])
         send(table_rows[i].op, table_rows[i].data_byte, table_rows[i].count,
              table_rows[i].known, table_rows[i].rsp);

      // long prefix, seven-bit suffix, full buffer, widest read
      load_buffer(5);
      send(OP_START, 0, 0, 0, z);
      for (int i = 0; i < 4; i++) send(OP_APPEND, 8'h00, 0, 0, z);
      send(OP_APPEND, 8'h01, 0, 0, z);
      send(OP_UE, 0, 0, 0, z);
      send(OP_START, 0, 0, 0, z);
      send(OP_APPEND, 8'h01, 0, 0, z);
      send(OP_APPEND, 8'hFF, 0, 0, z);
      send(OP_UE, 0, 0, 0, z);
      send(OP_START, 0, 0, 0, z);
      for (int i = 0; i < BUF_BYTES; i++) send(OP_APPEND, 8'($urandom), 0, 0, z);
      send(OP_APPEND, 8'hAA, 0, 0, z);
      send(OP_START, 0, 0, 0, z);
      for (int i = 0; i < 8; i++) send(OP_APPEND, 8'hFF, 0, 0, z);
      send(OP_READ, 0, 64, 0, z);

      for (int n = 0; n < RANDOM_ITEMS; ) begin
         if ($urandom_range(0, 19) == 0 || len_bytes == 0) begin
            k = $urandom_range(1, 12);
            load_buffer(k);
            n += k + 1;
         end else begin
            k = $urandom_range(0, 99);
            if (k < 25) op = OP_UE;
            else if (k < 45) op = OP_SE;
            else if (k < 60) op = OP_READ;
            else if (k < 68) op = OP_SKIP;
            else if (k < 75) op = OP_ALIGN;
            else if (k < 82) op = OP_PEEK;
            else if (k < 89) op = OP_MORE;
            else if (k < 95) op = OP_APPEND;
            else if (k < 97) op = OP_START;
            else op = op_type'($urandom_range(32'(OP_MORE) + 1, 32'(OP_NOP)));
            k = $urandom_range(0, 9);
            send(op, 8'($urandom),
                 k < 7 ? 16'($urandom_range(0, 40)) :
                 k < 9 ? 16'($urandom_range(41, 72)) : 16'($urandom), 0, z);
            n++;
         end
      end
      req_chan.valid <= 0;
      stim_done = 1;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_chan.ready <= 0;
      end else if ($urandom_range(0, 99) < 15) begin
         rsp_stall <= gap_len();
         rsp_chan.ready <= 0;
      end else rsp_chan.ready <= 1;
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = mk(rsp_chan.value, rsp_chan.signed_value, rsp_chan.flag, rsp_chan.ok,
                     rsp_chan.bits_left);
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transfer: %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: value %h/%h sval %h/%h flag %b/%b ok %b/%b left %0d/%0d",
                              want.value, got.value, want.signed_value, got.signed_value,
                              want.flag, got.flag, want.ok, got.ok,
                              want.bits_left, got.bits_left);
               end
            end
         end
      end
   end

   initial begin
      wait (reset == 0);
      forever begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
         if (stim_done && expected_rsps.size() == 0) begin
            repeat (200) @(posedge clock);
            if (errors == 0 && expected_rsps.size() == 0) begin
               $display("Verification passed");
            end else begin
               $display("Verification failed");
            end
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
